>>> design/lpr_pkg.sv
//------------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types for the LRU page frame replacement block.
//------------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

    // Sizing
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    // Port widths fixed by the interface
    localparam int PAGE_W  = 16;
    localparam int FIDX_W  = 4;
    localparam int CFG_W   = 5;
    localparam int TOTAL_W = 32;

    // Derived widths
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);

    // Frames in use after reset: a count of 16, clipped to FRAMES
    localparam int N_RESET = (FRAMES < 16) ? FRAMES : 16;

    // Page store port request
    typedef struct packed {
        logic                 we;
        logic [FRAME_W-1:0]   waddr;
        logic [PAGE_BITS-1:0] wdata;
        logic                 re;
        logic [FRAME_W-1:0]   raddr;
    } page_req_t;

    // Recency order store port request
    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] waddr;
        logic [FRAME_W-1:0] wdata;
        logic               re;
        logic [FRAME_W-1:0] raddr;
    } ord_req_t;

    // Per-item result from the engine
    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
    } res_t;

endpackage

`default_nettype wire

>>> design/lpr_ram.sv
//------------------------------------------------------------------------------
// lpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module lpr_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [ADDR_W-1:0]       raddr,
    output      logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lpr_engine.sv
//------------------------------------------------------------------------------
// lpr_engine
// Sequencer: scans the page store, then appends to or walks and compacts the recency order.
//------------------------------------------------------------------------------
`default_nettype none

module lpr_engine
    import lpr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [PAGE_BITS-1:0] s_page,
    output      page_req_t            pg_req,
    input  wire logic [PAGE_BITS-1:0] pg_rdata,
    output      ord_req_t             ord_req,
    input  wire logic [FRAME_W-1:0]   ord_rdata,
    output      logic                 res_valid,
    input  wire logic                 res_ready,
    output      res_t                 res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_OSCAN,
        ST_OTAIL,
        ST_FIN
    } state_t;

    state_t               state_reg,      state_next;
    logic [PAGE_BITS-1:0] page_reg,       page_next;
    logic [FRAME_W-1:0]   pidx_reg,       pidx_next;
    logic [FRAME_W-1:0]   oidx_reg,       oidx_next;
    logic [FRAME_W-1:0]   f_reg,          f_next;
    logic [FRAME_W-1:0]   free_reg,       free_next;
    logic                 free_found_reg, free_found_next;
    logic                 shift_reg,      shift_next;
    logic                 evict_reg,      evict_next;
    logic                 hit_reg,        hit_next;
    logic                 ev_rd_reg,      ev_rd_next;
    logic [PAGE_BITS-1:0] ev_page_reg,    ev_page_next;
    logic [FRAMES-1:0]    valid_reg,      valid_next;
    logic [CNT_W-1:0]     rc_reg,         rc_next;
    logic [CNT_W-1:0]     n_reg,          n_next;

    logic [CNT_W-1:0]     rc_last;
    logic [FRAME_W-1:0]   free_now;
    logic                 p_match;
    logic                 p_last;
    logic                 o_last;

    assign rc_last  = rc_reg - CNT_W'(1);
    assign p_match  = valid_reg[pidx_reg] && (pg_rdata == page_reg);
    assign p_last   = (pidx_reg == FRAME_W'(FRAMES - 1));
    assign o_last   = (CNT_W'(oidx_reg) == rc_last);
    assign free_now = free_found_reg ? free_reg : pidx_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);
    assign res       = '{hit: hit_reg, frame: f_reg, ev_valid: evict_reg, ev_page: ev_page_reg};

    always_comb begin
        state_next      = state_reg;
        page_next       = page_reg;
        pidx_next       = pidx_reg;
        oidx_next       = oidx_reg;
        f_next          = f_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        shift_next      = shift_reg;
        evict_next      = evict_reg;
        hit_next        = hit_reg;
        ev_rd_next      = 1'b0;
        ev_page_next    = ev_page_reg;
        valid_next      = valid_reg;
        rc_next         = rc_reg;
        n_next          = n_reg;
        pg_req          = '0;
        ord_req         = '0;

        // evicted page is on the read data in the cycle after its read
        if (ev_rd_reg) begin
            ev_page_next = pg_rdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    page_next       = s_page;
                    pidx_next       = '0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    evict_next      = 1'b0;
                    shift_next      = 1'b0;
                    ev_page_next    = '0;
                    pg_req.re       = 1'b1;
                    pg_req.raddr    = '0;
                    state_next      = ST_PSCAN;
                end
            end

            ST_PSCAN: begin
                if (!valid_reg[pidx_reg] && (CNT_W'(pidx_reg) < n_reg) && !free_found_reg) begin
                    free_next       = pidx_reg;
                    free_found_next = 1'b1;
                end
                if (p_match) begin
                    hit_next      = 1'b1;
                    f_next        = pidx_reg;
                    ord_req.re    = 1'b1;
                    ord_req.raddr = '0;
                    oidx_next     = '0;
                    state_next    = ST_OSCAN;
                end else if (p_last) begin
                    if (rc_reg < n_reg) begin
                        // fill the lowest free frame, append it to the order
                        f_next               = free_now;
                        pg_req.we            = 1'b1;
                        pg_req.waddr         = free_now;
                        pg_req.wdata         = page_reg;
                        valid_next[free_now] = 1'b1;
                        ord_req.we           = 1'b1;
                        ord_req.waddr        = FRAME_W'(rc_reg);
                        ord_req.wdata        = free_now;
                        rc_next              = rc_reg + CNT_W'(1);
                        state_next           = ST_FIN;
                    end else begin
                        evict_next    = 1'b1;
                        ord_req.re    = 1'b1;
                        ord_req.raddr = '0;
                        oidx_next     = '0;
                        state_next    = ST_OSCAN;
                    end
                end else begin
                    pg_req.re    = 1'b1;
                    pg_req.raddr = pidx_reg + FRAME_W'(1);
                    pidx_next    = pidx_reg + FRAME_W'(1);
                end
            end

            ST_OSCAN: begin
                if (evict_reg && (oidx_reg == '0)) begin
                    // head of the order is the victim
                    f_next       = ord_rdata;
                    shift_next   = 1'b1;
                    pg_req.re    = 1'b1;
                    pg_req.raddr = ord_rdata;
                    ev_rd_next   = 1'b1;
                end else if (!shift_reg) begin
                    if (ord_rdata == f_reg) begin
                        shift_next = 1'b1;
                    end
                end else begin
                    ord_req.we    = 1'b1;
                    ord_req.waddr = oidx_reg - FRAME_W'(1);
                    ord_req.wdata = ord_rdata;
                end
                if (o_last) begin
                    state_next = ST_OTAIL;
                end else begin
                    ord_req.re    = 1'b1;
                    ord_req.raddr = oidx_reg + FRAME_W'(1);
                    oidx_next     = oidx_reg + FRAME_W'(1);
                end
            end

            ST_OTAIL: begin
                ord_req.we    = 1'b1;
                ord_req.waddr = FRAME_W'(rc_last);
                ord_req.wdata = f_reg;
                if (evict_reg) begin
                    pg_req.we         = 1'b1;
                    pg_req.waddr      = f_reg;
                    pg_req.wdata      = page_reg;
                    valid_next[f_reg] = 1'b1;
                end
                state_next = ST_FIN;
            end

            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // frame count write empties every frame
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                n_next = CNT_W'(1);
            end else if (32'(cfg_wr_data) > FRAMES) begin
                n_next = CNT_W'(FRAMES);
            end else begin
                n_next = CNT_W'(cfg_wr_data);
            end
            valid_next = '0;
            rc_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rc_reg    <= '0;
            n_reg     <= CNT_W'(N_RESET);
            ev_rd_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rc_reg    <= rc_next;
            n_reg     <= n_next;
            ev_rd_reg <= ev_rd_next;
        end
        page_reg       <= page_next;
        pidx_reg       <= pidx_next;
        oidx_reg       <= oidx_next;
        f_reg          <= f_next;
        free_reg       <= free_next;
        free_found_reg <= free_found_next;
        shift_reg      <= shift_next;
        evict_reg      <= evict_next;
        hit_reg        <= hit_next;
        ev_page_reg    <= ev_page_next;
    end

endmodule

`default_nettype wire

>>> design/lru_page_frame_replacement.sv
//------------------------------------------------------------------------------
// lru_page_frame_replacement
// LRU page frame replacement: page and recency stores in RAM, one result
// item per page reference with saturating fault and access totals.
//------------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready  | s_page_number[15:0]
//  m_      | out | m_valid / m_ready  | m_hit, m_frame_index, m_evicted_valid,
//          |     |                    | m_evicted_page, m_fault_total, m_access_total
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data[4:0] (frame_count)
//
//  One item at a time. The page store is scanned one frame per cycle until a
//  hit or the last frame; a hit or a full miss then walks the recency order
//  one entry per cycle. Reset is synchronous; valid bits and counts clear and
//  frame_count returns to 16 at once, no clearing pass. A stalled result holds
//  in the output register while the next item is taken and worked on.
//------------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacement
    import lpr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    // page references
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire logic [PAGE_W-1:0]  s_page_number,
    // results
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic               m_hit,
    output      logic [FIDX_W-1:0]  m_frame_index,
    output      logic               m_evicted_valid,
    output      logic [PAGE_W-1:0]  m_evicted_page,
    output      logic [TOTAL_W-1:0] m_fault_total,
    output      logic [TOTAL_W-1:0] m_access_total
);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    page_req_t            pg_req;
    ord_req_t             ord_req;
    logic [PAGE_BITS-1:0] pg_rdata;
    logic [FRAME_W-1:0]   ord_rdata;
    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;

    // Output register and running totals
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [FIDX_W-1:0]    m_frame_reg;
    logic                 m_ev_valid_reg;
    logic [PAGE_W-1:0]    m_ev_page_reg;
    logic [TOTAL_W-1:0]   fault_count_reg,  fault_count_next;
    logic [TOTAL_W-1:0]   access_count_reg, access_count_next;

    // Page number held by each frame
    lpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .clk   (aclk),
        .we    (pg_req.we),
        .waddr (pg_req.waddr),
        .wdata (pg_req.wdata),
        .re    (pg_req.re),
        .raddr (pg_req.raddr),
        .rdata (pg_rdata)
    );

    // Frame numbers, least recently used first
    lpr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_order_ram (
        .clk   (aclk),
        .we    (ord_req.we),
        .waddr (ord_req.waddr),
        .wdata (ord_req.wdata),
        .re    (ord_req.re),
        .raddr (ord_req.raddr),
        .rdata (ord_rdata)
    );

    lpr_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_page      (PAGE_BITS'(s_page_number)),
        .pg_req      (pg_req),
        .pg_rdata    (pg_rdata),
        .ord_req     (ord_req),
        .ord_rdata   (ord_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Engine hands over its result once the output register is free
    assign res_ready = !m_valid_reg || m_ready;

    // Totals count at hand-over; a fault counts only on a miss
    always_comb begin
        access_count_next = access_count_reg;
        fault_count_next  = fault_count_reg;
        if (res_valid && res_ready) begin
            if (access_count_reg != TOTAL_MAX) begin
                access_count_next = access_count_reg + TOTAL_W'(1);
            end
            if (!res.hit && (fault_count_reg != TOTAL_MAX)) begin
                fault_count_next = fault_count_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            fault_count_reg  <= '0;
            access_count_reg <= '0;
        end else begin
            fault_count_reg  <= fault_count_next;
            access_count_reg <= access_count_next;
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            m_hit_reg      <= res.hit;
            m_frame_reg    <= FIDX_W'(res.frame);
            m_ev_valid_reg <= res.ev_valid;
            m_ev_page_reg  <= PAGE_W'(res.ev_page);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_frame_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_total   = fault_count_reg;
    assign m_access_total  = access_count_reg;

endmodule

`default_nettype wire

>>> design/lpr_checker.sv
//------------------------------------------------------------------------------
// lpr_checker
// Port-level checks on the result channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module lpr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_hit,
    input wire logic [3:0]  m_frame_index,
    input wire logic        m_evicted_valid,
    input wire logic [15:0] m_evicted_page,
    input wire logic [31:0] m_fault_total,
    input wire logic [31:0] m_access_total
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_index) && $stable(m_hit)
            && $stable(m_evicted_page) && $stable(m_access_total))
        else $error("result changed while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted_valid))
        else $error("hit with eviction");

    // no eviction reports page zero
    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == 16'd0)
        else $error("evicted page nonzero without eviction");

    // faults never outnumber accesses
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fault_total <= m_access_total)
        else $error("fault total above access total");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lru_page_frame_replacement lpr_checker u_lpr_checker (.*);

`default_nettype wire

>>> test/lru_page_frame_replacement_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// lru_page_frame_replacement_tb
// Self-checking bench for the LRU page frame replacement block. Page
// references go in over a valid/ready channel. A local LRU model of the
// frames, the recency order and the saturating totals computes each
// expected result. The run works through several frame counts, the
// out-of-range ones among them. It also goes through four handshake
// pressure modes and checks every result item field by field.
//------------------------------------------------------------------------------

module lru_page_frame_replacement_tb;
    import lpr_pkg::*;

    // Result item as the block reports it
    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [TOTAL_W-1:0] fault_total;
        logic [TOTAL_W-1:0] access_total;
    } page_outcome_t;

    localparam int DRAIN_CYCLES = 48;    // above the worst case for one item

    // DUT ports, the driven inputs known from time zero
    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_wr_en       = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data     = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [PAGE_W-1:0]  s_page_number   = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_hit;
    logic [FIDX_W-1:0]  m_frame_index;
    logic               m_evicted_valid;
    logic [PAGE_W-1:0]  m_evicted_page;
    logic [TOTAL_W-1:0] m_fault_total;
    logic [TOTAL_W-1:0] m_access_total;

    // Traffic shaping, in percent of cycles
    int unsigned send_gap_pct    = 0;
    int unsigned ready_stall_pct = 0;

    logic [PAGE_W-1:0] page_refs_pending [$];
    page_outcome_t     outcomes_due [$];
    int unsigned       bad_results = 0;

    // LRU model state
    logic [PAGE_W-1:0] frame_page   [FRAMES];
    bit                frame_used   [FRAMES];
    int unsigned       lru_list     [FRAMES];   // frame numbers, oldest first
    int unsigned       n_resident   = 0;
    logic [TOTAL_W-1:0] faults_seen  = '0;
    logic [TOTAL_W-1:0] refs_seen    = '0;
    logic [CFG_W-1:0]  frames_setting = 5'd16;

    lru_page_frame_replacement dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_total   (m_fault_total),
        .m_access_total  (m_access_total)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Drop order entry pos and append frame f as most recent
    function automatic void make_most_recent(int unsigned pos, int unsigned f);
        int unsigned i;
        for (i = pos; i + 1 < n_resident; i++)
            lru_list[i] = lru_list[i + 1];
        if (n_resident >= 1)
            lru_list[n_resident - 1] = f;
    endfunction

    // Effective frame count: 0 acts as 1, anything above FRAMES as FRAMES
    function automatic int unsigned frames_in_use();
        if (frames_setting == 0)
            return 1;
        if (frames_setting > FRAMES)
            return FRAMES;
        return frames_setting;
    endfunction

    // Look a page up, update the LRU state and queue the expected result
    function automatic void predict_lookup(logic [PAGE_W-1:0] page);
        page_outcome_t r;
        int unsigned   n;
        int unsigned   f;
        int unsigned   pos;
        int unsigned   i;
        bit            found;
        r     = '0;
        n     = frames_in_use();
        f     = 0;
        found = 1'b0;
        for (i = 0; i < FRAMES; i++) begin
            if (!found && frame_used[i] && frame_page[i] == page) begin
                f     = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            pos   = 0;
            for (i = 0; i < n_resident; i++) begin
                if (lru_list[i] == f) begin
                    pos = i;
                    break;
                end
            end
            make_most_recent(pos, f);
        end else begin
            if (n_resident < n) begin
                // lowest free frame
                f = n_resident;
                for (i = 0; i < n; i++) begin
                    if (!frame_used[i]) begin
                        f = i;
                        break;
                    end
                end
                frame_used[f] = 1'b1;
                frame_page[f] = page;
                n_resident++;
                lru_list[n_resident - 1] = f;
            end else begin
                // replace the least recently used frame
                f               = lru_list[0];
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_page[f];
                frame_page[f]   = page;
                frame_used[f]   = 1'b1;
                make_most_recent(0, f);
            end
            if (faults_seen != '1)
                faults_seen++;
        end
        if (refs_seen != '1)
            refs_seen++;
        r.frame_index  = f[FIDX_W-1:0];
        r.fault_total  = faults_seen;
        r.access_total = refs_seen;
        outcomes_due.push_back(r);
    endfunction

    // Sender: one item per handshake, valid held until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_lookup(s_page_number);
            if (!s_valid || s_ready) begin
                if (page_refs_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_valid       <= 1'b1;
                    s_page_number <= page_refs_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, compare against the oldest expectation
    always @(posedge aclk) begin : result_monitor
        page_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result: hit=%0b frame=%0d ev=%0b/%h",
                                 m_hit, m_frame_index, m_evicted_valid, m_evicted_page);
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_hit !== want.hit || m_frame_index !== want.frame_index ||
                        m_evicted_valid !== want.evicted_valid ||
                        m_evicted_page !== want.evicted_page ||
                        m_fault_total !== want.fault_total ||
                        m_access_total !== want.access_total) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("mismatch exp: hit=%0b frame=%0d ev=%0b/%h faults=%0d refs=%0d",
                                     want.hit, want.frame_index, want.evicted_valid,
                                     want.evicted_page, want.fault_total, want.access_total);
                            $display("         got: hit=%0b frame=%0d ev=%0b/%h faults=%0d refs=%0d",
                                     m_hit, m_frame_index, m_evicted_valid, m_evicted_page,
                                     m_fault_total, m_access_total);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Wait until the sender is empty and every result is back
    task automatic wait_all_done();
        @(negedge aclk);
        while (page_refs_pending.size() != 0 || s_valid || outcomes_due.size() != 0)
            @(negedge aclk);
    endtask

    // Frame count write while idle; the block empties all frames
    task automatic write_frame_count(logic [CFG_W-1:0] value);
        int unsigned i;
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        frames_setting = value;
        for (i = 0; i < FRAMES; i++)
            frame_used[i] = 1'b0;
        n_resident = 0;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick an idle mode: none, sender gaps, receiver stalls, both
    task automatic set_traffic(int unsigned mode);
        @(negedge aclk);
        case (mode % 4)
            0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
            1: begin send_gap_pct = 49; ready_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  ready_stall_pct = 49; end
            default: begin send_gap_pct = 20; ready_stall_pct = 20; end
        endcase
    endtask

    task automatic queue_page(logic [PAGE_W-1:0] page);
        page_refs_pending.push_back(page);
    endtask

    // Random references: mostly a working set a bit larger than the frames
    // so hits, fills and evictions all occur; some fully random pages.
    task automatic queue_random(int unsigned count);
        logic [PAGE_W-1:0] working_set [$];
        logic [PAGE_W-1:0] last_page;
        int unsigned       set_size;
        int unsigned       k;
        int unsigned       roll;
        set_size  = frames_in_use() + $urandom_range(0, frames_in_use() / 2 + 2);
        last_page = PAGE_W'($urandom);
        for (k = 0; k < set_size; k++)
            working_set.push_back(PAGE_W'($urandom));
        @(negedge aclk);
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 70)
                last_page = working_set[$urandom_range(0, set_size - 1)];
            else if (roll < 85)
                last_page = last_page;      // immediate re-reference
            else
                last_page = PAGE_W'($urandom);
            queue_page(last_page);
        end
    endtask

    // Random part of a phase, split by a full drain so the sender sits idle
    task automatic random_phase(int unsigned count);
        queue_random(count / 2);
        wait_all_done();
        queue_random(count - count / 2);
    endtask

    initial begin : stimulus
        int unsigned       ph;
        logic [CFG_W-1:0]  sweep [7];
        for (int i = 0; i < FRAMES; i++) begin
            frame_used[i] = 1'b0;
            frame_page[i] = '0;
            lru_list[i]   = 0;
        end
        sweep = '{5'd4, 5'd17, 5'd1, 5'd9, 5'd16, 5'd3, 5'd31};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset frame count of 16: extremes of the page field and a hit
        set_traffic(0);
        @(negedge aclk);
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'h8000);
        queue_page(16'h0001);
        queue_page(16'hFFFF);
        random_phase(40);

        // Two frames: pages from before must fault again after the write,
        // then hit at the LRU end and evictions in both frames
        write_frame_count(5'd2);
        set_traffic(1);
        @(negedge aclk);
        queue_page(16'h0000);
        queue_page(16'h5555);
        queue_page(16'h0000);
        queue_page(16'hAAAA);
        queue_page(16'h5555);
        queue_page(16'hAAAA);
        random_phase(30);

        // Zero acts as a single frame
        write_frame_count(5'd0);
        set_traffic(2);
        @(negedge aclk);
        queue_page(16'h7FFF);
        queue_page(16'h7FFF);
        queue_page(16'h0000);
        queue_page(16'h7FFF);
        random_phase(30);

        // Remaining settings, 31 clipped to FRAMES among them
        for (ph = 0; ph < 7; ph++) begin
            write_frame_count(sweep[ph]);
            set_traffic(ph + 3);
            random_phase(frames_in_use() > 8 ? 50 : 30);
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_results == 0)
            $display("[lru_page_frame_replacement] OK");
        else
            $display("[lru_page_frame_replacement] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #(8_000_000);
        $display("[lru_page_frame_replacement] ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/lpr_pkg.sv
design/lpr_ram.sv
design/lpr_engine.sv
design/lru_page_frame_replacement.sv
design/lpr_checker.sv
test/lru_page_frame_replacement_tb.sv
